/* hdl/lcps_pkg.sv */
// ----------------------------------------------------------------------------
// lcps_pkg
// Shared types and constants for the LED chaser pattern sequencer.
// ----------------------------------------------------------------------------
package lcps_pkg;

    localparam int COLOR_W    = 24;
    localparam int LIGHT_W    = 6;   // light count / light counter width
    localparam int INDEX_W    = 5;   // light_index field width
    localparam int MAX_LIGHTS = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int OFFSET_W   = 10;  // frames within a motion or pause phase

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LIGHTS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_LEFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_RIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_PAUSE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_PAUSE   = 3'd5;

    typedef enum logic [2:0] {
        PH_SCROLL_LEFT  = 3'd0,
        PH_SCROLL_RIGHT = 3'd1,
        PH_FILL_LEFT    = 3'd2,
        PH_CRISS        = 3'd3,
        PH_FILL_RIGHT   = 3'd4,
        PH_BLINK        = 3'd5,
        PH_PAUSE        = 3'd6
    } phase_t;

    typedef struct packed {
        logic [COLOR_W-1:0] on_color;
        logic [COLOR_W-1:0] off_color;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] light_index;
        logic [COLOR_W-1:0] color;
        logic               lit;
        logic [2:0]         phase;
        logic               last;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic start;    // latch frame colors, rewind light counter
        logic emit;     // load result register with current light
        logic advance;  // step the frame sequence
    } lcps_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last_light;
    } lcps_stat_t;

endpackage

/* hdl/lcps_ctrl.sv */
// ----------------------------------------------------------------------------
// lcps_ctrl
// Frame controller: takes one frame beat, then issues one light per cycle
// into the result register as the consumer drains it.
// ----------------------------------------------------------------------------
module lcps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  lcps_pkg::lcps_stat_t stat,
    output lcps_pkg::lcps_cmd_t  cmd
);
    import lcps_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_load;

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign can_load     = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (can_load)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (stat.last_light)
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/lcps_datapath.sv */
// ----------------------------------------------------------------------------
// lcps_datapath
// Config registers, phase tracker, per-light pattern decision and the
// result register.
// ----------------------------------------------------------------------------
module lcps_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lcps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lcps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  lcps_pkg::item_t                     item,
    input  lcps_pkg::lcps_cmd_t                 cmd,
    output lcps_pkg::lcps_stat_t                stat,
    output lcps_pkg::result_t                   result
);
    import lcps_pkg::*;

    // configuration
    logic [5:0]          num_lights_reg, group_left_reg, group_right_reg;
    logic [7:0]          blink_count_reg, blink_pause_reg;
    logic [9:0]          end_pause_reg;
    logic                cfg_hit;

    // frame sequence state (equivalent to a single frame step count)
    phase_t              phase_reg, phase_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [7:0]          sub_reg, sub_next;       // frames into blink half period
    logic [7:0]          periods_reg, periods_next;
    logic                parity_reg, parity_next;

    // frame beat
    logic [COLOR_W-1:0]  on_reg, off_reg;
    logic [LIGHT_W-1:0]  light_reg;
    result_t             result_reg;

    logic [LIGHT_W-1:0]  nl;
    logic [OFFSET_W:0]   offset_inc;
    logic [8:0]          sub_inc, periods_inc;
    logic                blink_on;
    phase_t              after_fill;
    phase_t              after_blink;
    logic [6:0]          n7, s7, m7, gl7, gr7;
    logic                lit;
    logic                left_grp, right_grp;

    // light count clamped to 1..MAX_LIGHTS
    always_comb
    begin
        if (num_lights_reg == '0)
            nl = LIGHT_W'(1);
        else if (num_lights_reg > LIGHT_W'(MAX_LIGHTS))
            nl = LIGHT_W'(MAX_LIGHTS);
        else
            nl = num_lights_reg;
    end

    assign cfg_hit = cfg_write && (cfg_index <= REG_END_PAUSE);

    // ---- frame sequence stepping ----
    assign offset_inc  = {1'b0, offset_reg} + 1'b1;
    assign sub_inc     = {1'b0, sub_reg} + 1'b1;
    assign periods_inc = {1'b0, periods_reg} + 1'b1;
    assign blink_on    = (blink_pause_reg != '0) && (blink_count_reg != '0);
    assign after_blink = (end_pause_reg != '0) ? PH_PAUSE : PH_SCROLL_LEFT;
    assign after_fill  = blink_on ? PH_BLINK : after_blink;

    always_comb
    begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        sub_next     = sub_reg;
        periods_next = periods_reg;
        parity_next  = parity_reg;
        if (cfg_hit)
        begin
            phase_next   = PH_SCROLL_LEFT;
            offset_next  = '0;
            sub_next     = '0;
            periods_next = '0;
            parity_next  = 1'b0;
        end
        else if (cmd.advance)
        begin
            case (phase_reg)
                PH_SCROLL_LEFT, PH_SCROLL_RIGHT, PH_FILL_LEFT, PH_CRISS, PH_FILL_RIGHT:
                begin
                    if (offset_inc == (OFFSET_W+1)'(nl))
                    begin
                        offset_next  = '0;
                        sub_next     = '0;
                        periods_next = '0;
                        parity_next  = 1'b0;
                        if (phase_reg == PH_FILL_RIGHT)
                            phase_next = after_fill;
                        else
                            phase_next = phase_t'(phase_reg + 3'd1);
                    end
                    else
                    begin
                        offset_next = offset_inc[OFFSET_W-1:0];
                    end
                end
                PH_BLINK:
                begin
                    if (sub_inc == {1'b0, blink_pause_reg})
                    begin
                        sub_next    = '0;
                        parity_next = !parity_reg;
                        if (periods_inc == {1'b0, blink_count_reg})
                        begin
                            phase_next  = after_blink;
                            offset_next = '0;
                        end
                        else
                        begin
                            periods_next = periods_inc[7:0];
                        end
                    end
                    else
                    begin
                        sub_next = sub_inc[7:0];
                    end
                end
                PH_PAUSE:
                begin
                    if (offset_inc == {1'b0, end_pause_reg})
                    begin
                        phase_next  = PH_SCROLL_LEFT;
                        offset_next = '0;
                    end
                    else
                    begin
                        offset_next = offset_inc[OFFSET_W-1:0];
                    end
                end
                default:
                begin
                    phase_next  = PH_SCROLL_LEFT;
                    offset_next = '0;
                end
            endcase
        end
    end

    // ---- pattern decision for the current light ----
    assign n7  = {1'b0, light_reg};
    assign s7  = 7'(offset_reg[LIGHT_W-1:0]);
    assign m7  = 7'(nl) - 7'd1 - s7;
    assign gl7 = {1'b0, group_left_reg};
    assign gr7 = {1'b0, group_right_reg};
    assign left_grp  = (n7 >= s7) && (n7 < s7 + gl7);
    assign right_grp = (n7 <= m7) && (n7 + gl7 > m7);

    always_comb
    begin
        case (phase_reg)
            PH_SCROLL_LEFT:  lit = left_grp;
            PH_SCROLL_RIGHT: lit = (n7 <= m7) && (n7 + gr7 > m7);
            PH_FILL_LEFT:    lit = (n7 <= s7);
            PH_CRISS:        lit = left_grp || right_grp;
            PH_FILL_RIGHT:   lit = (n7 >= m7);
            PH_BLINK:        lit = light_reg[0] ^ parity_reg;
            default:         lit = 1'b0;
        endcase
    end

    assign stat.last_light = (light_reg + LIGHT_W'(1)) == nl;
    assign result          = result_reg;

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_lights_reg  <= 6'd32;
            group_left_reg  <= 6'd1;
            group_right_reg <= 6'd1;
            blink_count_reg <= 8'd4;
            blink_pause_reg <= 8'd8;
            end_pause_reg   <= 10'd32;
            phase_reg       <= PH_SCROLL_LEFT;
            offset_reg      <= '0;
            sub_reg         <= '0;
            periods_reg     <= '0;
            parity_reg      <= 1'b0;
            light_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_NUM_LIGHTS:  num_lights_reg  <= cfg_data[5:0];
                    REG_GROUP_LEFT:  group_left_reg  <= cfg_data[5:0];
                    REG_GROUP_RIGHT: group_right_reg <= cfg_data[5:0];
                    REG_BLINK_COUNT: blink_count_reg <= cfg_data[7:0];
                    REG_BLINK_PAUSE: blink_pause_reg <= cfg_data[7:0];
                    REG_END_PAUSE:   end_pause_reg   <= cfg_data;
                    default:         ;
                endcase
            end
            phase_reg   <= phase_next;
            offset_reg  <= offset_next;
            sub_reg     <= sub_next;
            periods_reg <= periods_next;
            parity_reg  <= parity_next;
            if (cmd.start)
                light_reg <= '0;
            else if (cmd.emit)
                light_reg <= light_reg + LIGHT_W'(1);
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            on_reg  <= item.on_color;
            off_reg <= item.off_color;
        end
        if (cmd.emit)
        begin
            result_reg.light_index <= light_reg[INDEX_W-1:0];
            result_reg.color       <= lit ? on_reg : off_reg;
            result_reg.lit         <= lit;
            result_reg.phase       <= phase_reg;
            result_reg.last        <= stat.last_light;
        end
    end

endmodule

/* hdl/led_chaser_pattern_sequencer_top.sv */
// ----------------------------------------------------------------------------
// led_chaser_pattern_sequencer_top
// LED chaser: one frame beat in, one result beat per light out.
// ----------------------------------------------------------------------------
// Each accepted item beat is one frame tick carrying an on and an off color.
// The block answers with num_lights result beats (clamped to 1..32), light 0
// first, the final one flagged by last. Results leave one per cycle, while
// the consumer does not stall, from a single output register. The next frame
// beat is taken once the final light of the current frame sits in the output
// register, even if it has not been taken yet. The pattern steps through
// scroll left, scroll right, fill left, criss-cross, fill right, alternate
// blink (skipped when blink count or blink pause is zero) and a dark pause
// (skipped when end_pause is zero), then restarts; it advances once per
// frame. Config writes (cfg_write, cfg_index, cfg_data) take effect in the
// cycle after the write and restart the pattern; indexes past end_pause are
// ignored. Write config only while no frame is in flight.
// ----------------------------------------------------------------------------
module led_chaser_pattern_sequencer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [lcps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lcps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  lcps_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output lcps_pkg::result_t                result
);
    import lcps_pkg::*;

    lcps_cmd_t  cmd;
    lcps_stat_t stat;

    // Controller: frame handshake and output register occupancy.
    lcps_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Datapath: config, phase tracking, lit decision, result payload.
    lcps_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule
